// ----- rtl/core/nwk_pkg.sv -----
// Shared types, constants and helpers for the Newick structure parser.
// No dependencies; imported by nwk_front, nwk_back and the top level.
`default_nettype none

package nwk_pkg;

	// Stack and id sizing
	localparam int MAX_DEPTH = 64;
	localparam int ID_WIDTH  = 16;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int ADDR_W    = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;

	// Front-to-back request queue (power of two depth)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Special characters
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	// Event kinds
	localparam logic [1:0] EV_OPEN  = 2'd0;
	localparam logic [1:0] EV_TEXT  = 2'd1;
	localparam logic [1:0] EV_CLOSE = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

	typedef logic [ID_WIDTH-1:0] id_t;

	typedef enum logic [2:0] {
		OP_OPEN,
		OP_CLOSE,
		OP_COMMA,
		OP_SEMI,
		OP_TEXT
	} op_t;

	// One classified request
	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic       colon;
	} q_entry_t;

	// Low 16 bits of an id, zero extended when ids are narrower
	function automatic logic [15:0] id_out(input id_t v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nwk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nwk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                   wdata,
	input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/nwk_front.sv -----
// Front end: accepts text bytes, classifies them and queues requests.
// Depends on nwk_pkg.
`default_nettype none

module nwk_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        text_byte,
	output logic                   q_valid,
	output nwk_pkg::q_entry_t      q_head,
	input  wire logic              q_pop
);
	import nwk_pkg::*;

	q_entry_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	q_entry_t          cls;

	assign in_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_head   = entry_q[rd_ptr_q];

	always_comb begin
		cls.ch    = text_byte;
		cls.colon = (text_byte == CH_COLON);
		case (text_byte)
			CH_LPAREN: cls.op = OP_OPEN;
			CH_RPAREN: cls.op = OP_CLOSE;
			CH_COMMA:  cls.op = OP_COMMA;
			CH_SEMI:   cls.op = OP_SEMI;
			default:   cls.op = OP_TEXT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(q_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("request queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty request queue");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ----- rtl/core/nwk_back.sv -----
// Back end: executes queued requests against the open-node stack and
// drives the result register. Depends on nwk_pkg and nwk_ram.
`default_nettype none

module nwk_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire nwk_pkg::q_entry_t q_head,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             event_kind,
	output logic [15:0]            node_id,
	output logic [15:0]            parent_id,
	output logic                   has_parent,
	output logic [7:0]             char_out,
	output logic                   in_length,
	output logic                   is_root_close,
	output logic [1:0]             error_code,
	output logic                   last
);
	import nwk_pkg::*;

	// Control state
	logic [DEPTH_W-1:0] depth_q;
	id_t                next_id_q;
	logic               in_text_q;
	logic               after_colon_q;
	logic               finished_q;
	logic               out_valid_q;

	// Top two stack entries live in flops; the rest sit in the RAM
	id_t                top_q;
	id_t                second_q;
	id_t                third;
	logic               byp_q;
	id_t                byp_data_q;

	// Next-state values
	logic [DEPTH_W-1:0] depth_n;
	id_t                next_id_n;
	id_t                top_n;
	id_t                second_n;
	logic               in_text_n;
	logic               after_colon_n;
	logic               finished_n;

	// RAM ports
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ADDR_W-1:0]  ram_raddr;
	id_t                ram_rdata;
	logic [DEPTH_W-1:0] dm2;
	logic [DEPTH_W-1:0] dn3;

	// Result under construction
	logic               adv;
	logic               emit;
	logic               load_out;
	logic [1:0]         ev_kind;
	id_t                ev_node;
	id_t                ev_par;
	logic               ev_hp;
	logic [7:0]         ev_char;
	logic               ev_len;
	logic               ev_root;
	logic [1:0]         ev_err;
	logic               ev_last;

	logic               empty;
	logic               full;

	assign adv      = !out_valid_q || !out_stall;
	assign load_out = adv && emit;
	assign third    = byp_q ? byp_data_q : ram_rdata;
	assign empty    = (depth_q == '0);
	assign full     = (depth_q == DEPTH_W'(MAX_DEPTH));
	assign dm2      = depth_q - DEPTH_W'(2);
	assign ram_waddr = dm2[ADDR_W-1:0];
	assign dn3      = depth_n - DEPTH_W'(3);
	assign ram_raddr = dn3[ADDR_W-1:0];

	always_comb begin
		depth_n       = depth_q;
		next_id_n     = next_id_q;
		top_n         = top_q;
		second_n      = second_q;
		in_text_n     = in_text_q;
		after_colon_n = after_colon_q;
		finished_n    = finished_q;
		ram_we        = 1'b0;
		q_pop         = 1'b0;
		emit          = 1'b0;
		ev_kind       = EV_OPEN;
		ev_node       = '0;
		ev_par        = '0;
		ev_hp         = 1'b0;
		ev_char       = '0;
		ev_len        = 1'b0;
		ev_root       = 1'b0;
		ev_err        = ERR_NONE;
		ev_last       = 1'b1;

		if (q_valid && finished_q) begin
			// Trailing bytes after the end or an error are dropped
			q_pop = 1'b1;
		end else if (q_valid && adv) begin
			emit = 1'b1;
			case (q_head.op)
				OP_OPEN, OP_TEXT: begin
					if (q_head.op == OP_TEXT && in_text_q) begin
						// Text byte for the node on top
						after_colon_n = after_colon_q | q_head.colon;
						ev_kind = EV_TEXT;
						ev_node = empty ? '0 : top_q;
						ev_hp   = (depth_q > DEPTH_W'(1));
						ev_par  = second_q;
						ev_char = q_head.ch;
						ev_len  = after_colon_n;
						q_pop   = 1'b1;
					end else if (full) begin
						ev_kind    = EV_ERROR;
						ev_err     = ERR_OVERFLOW;
						finished_n = 1'b1;
						q_pop      = 1'b1;
					end else begin
						// Push a new node; a leaf's first byte stays queued
						// and is taken again as its text event when the output advances
						ev_kind   = EV_OPEN;
						ev_node   = next_id_q;
						ev_par    = top_q;
						ev_hp     = !empty;
						top_n     = next_id_q;
						second_n  = top_q;
						depth_n   = depth_q + DEPTH_W'(1);
						next_id_n = next_id_q + ID_WIDTH'(1);
						ram_we    = (depth_q >= DEPTH_W'(2));
						if (q_head.op == OP_TEXT) begin
							in_text_n = 1'b1;
							ev_last   = 1'b0;
						end else begin
							in_text_n = 1'b0;
							q_pop     = 1'b1;
						end
					end
				end
				OP_CLOSE, OP_COMMA, OP_SEMI: begin
					q_pop = 1'b1;
					if (empty) begin
						ev_kind    = EV_ERROR;
						ev_err     = ERR_UNDERFLOW;
						finished_n = 1'b1;
					end else begin
						ev_kind       = EV_CLOSE;
						ev_node       = top_q;
						ev_par        = second_q;
						ev_hp         = (depth_q > DEPTH_W'(1));
						ev_root       = (q_head.op == OP_SEMI);
						top_n         = second_q;
						second_n      = third;
						depth_n       = depth_q - DEPTH_W'(1);
						after_colon_n = 1'b0;
						in_text_n     = (q_head.op == OP_CLOSE);
						if (q_head.op == OP_SEMI) begin
							finished_n = 1'b1;
						end
					end
				end
				default: begin
					emit  = 1'b0;
					q_pop = 1'b1;
				end
			endcase
		end
	end

	nwk_ram #(
		.WIDTH (ID_WIDTH),
		.DEPTH (MAX_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (second_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q       <= '0;
			next_id_q     <= '0;
			in_text_q     <= 1'b0;
			after_colon_q <= 1'b0;
			finished_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			depth_q       <= depth_n;
			next_id_q     <= next_id_n;
			in_text_q     <= in_text_n;
			after_colon_q <= after_colon_n;
			finished_q    <= finished_n;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q      <= top_n;
		second_q   <= second_n;
		// Write and read on the same RAM word: forward the written value
		byp_q      <= ram_we && (ram_waddr == ram_raddr);
		byp_data_q <= second_q;
		if (load_out) begin
			event_kind    <= ev_kind;
			node_id       <= id_out(ev_node);
			parent_id     <= ev_hp ? id_out(ev_par) : 16'h0000;
			has_parent    <= ev_hp;
			char_out      <= ev_char;
			in_length     <= ev_len;
			is_root_close <= ev_root;
			error_code    <= ev_err;
			last          <= ev_last;
		end
	end

	assign out_valid = out_valid_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_DEPTH))
		else $error("stack depth beyond limit");

	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag cleared");

	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && ev_kind == EV_ERROR) |=> finished_q)
		else $error("error result without stop");

	a_open_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && ev_kind == EV_OPEN) |=>
		(next_id_q == id_t'($past(next_id_q) + ID_WIDTH'(1))))
		else $error("node id counter did not advance on open");

endmodule

`default_nettype wire

// ----- rtl/core/newick_tree_structure_parser_unit.sv -----
// Top level of the Newick tree structure parser.
// Depends on nwk_pkg, nwk_front, nwk_back (and nwk_ram through nwk_back).
//
// Usage:
//  - Input channel (in_valid / in_stall / text_byte): one character of the
//    Newick text per request. A byte is taken on a rising edge with in_valid
//    high and in_stall low.
//  - Output channel (out_valid / out_stall / result fields): events of kind
//    node opened, text byte, node closed, or error; one per request, two for a
//    leaf's first text byte. last marks the final event caused by an input byte.
//  - Path: an accepted byte is written into the request queue; the back end
//    takes it from the queue head and loads its first event into the result
//    register once the queue ahead of it is empty and the output is free.
//  - Throughput: one byte per cycle while in_stall is low. A leaf's first
//    text byte gives two events (open, then text) and holds the back end for
//    both; the four-entry request queue absorbs occasional leaf openings, while
//    a sustained stream of more than one event per byte stalls the input.
//    The single result register limits output to one event per unstalled cycle.
//  - Bytes after ';' or after an error are accepted and give no event.
//  - Reset (arst_n low) empties the queue and the stack, clears the id
//    counter and all flags; the block accepts bytes right after release.
//  - When out_stall is high the result register holds; the back end waits,
//    the queue fills, and in_stall rises once four requests are waiting.
`default_nettype none

module newick_tree_structure_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_byte,
	// Output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       event_kind,
	output logic [15:0]      node_id,
	output logic [15:0]      parent_id,
	output logic             has_parent,
	output logic [7:0]       char_out,
	output logic             in_length,
	output logic             is_root_close,
	output logic [1:0]       error_code,
	output logic             last
);
	import nwk_pkg::*;

	// Classified requests between front and back
	logic     q_valid;
	logic     q_pop;
	q_entry_t q_head;

	// Front: take bytes, decode the special characters, queue them
	nwk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.text_byte (text_byte),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	// Back: run the stack, id counter and text flags; own the result register
	nwk_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.node_id       (node_id),
		.parent_id     (parent_id),
		.has_parent    (has_parent),
		.char_out      (char_out),
		.in_length     (in_length),
		.is_root_close (is_root_close),
		.error_code    (error_code),
		.last          (last)
	);

endmodule

`default_nettype wire
